// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bbr_pkg.sv =====
package bbr_pkg;

  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 1024;

  localparam int PosW     = 13;
  localparam int SizeW    = 11;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;
  localparam int CntW     = 4;
  localparam int SumW     = 12;
  localparam int RecipW   = 17;
  localparam int ProdW    = SumW + RecipW;
  localparam int RecipShift = 16;
  localparam int QueueDepth = 2;
  localparam int TapW     = 4;
  localparam logic [TapW-1:0] LastTap = TapW'(8);

  localparam logic [SizeW-1:0] WidthReset  = SizeW'(640);
  localparam logic [SizeW-1:0] HeightReset = SizeW'(480);

  localparam logic [CfgIdxW-1:0] CfgImageWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgImageHeight = CfgIdxW'(1);

  localparam logic OpPixel = 1'b0;

  typedef struct packed {
    logic        operation;
    logic [31:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        frame_last;
  } out_item_t;

  typedef struct packed {
    logic            store;
    logic            emit;
    logic            last;
    logic [PosW-1:0] wrow;
    logic [PosW-1:0] wcol;
    logic [PosW-1:0] orow;
    logic [PosW-1:0] ocol;
    logic [31:0]     pixel;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_DRAIN,
    BK_MUL,
    BK_OUT
  } bk_state_e;

  function automatic logic [PosW-1:0] clamp_size(logic [SizeW-1:0] v, int maxv);
    if (v == '0) return PosW'(1);
    if (int'(v) > maxv) return PosW'(maxv);
    return PosW'(v);
  endfunction

  // ceil(2^16 / count), exact for every sum of up to nine 8-bit values
  function automatic logic [RecipW-1:0] recip(logic [CntW-1:0] c);
    logic [RecipW-1:0] r;
    r = '0;
    case (c)
      CntW'(1): r = RecipW'(65536);
      CntW'(2): r = RecipW'(32768);
      CntW'(3): r = RecipW'(21846);
      CntW'(4): r = RecipW'(16384);
      CntW'(6): r = RecipW'(10923);
      CntW'(9): r = RecipW'(7282);
      default:  r = '0;
    endcase
    return r;
  endfunction

  // tap to {row offset, column offset}, each offset biased by one
  function automatic logic [3:0] tap_offs(logic [TapW-1:0] t);
    logic [3:0] o;
    o = 4'b0101;
    case (t)
      TapW'(0): o = 4'b00_00;
      TapW'(1): o = 4'b00_01;
      TapW'(2): o = 4'b00_10;
      TapW'(3): o = 4'b01_00;
      TapW'(4): o = 4'b01_01;
      TapW'(5): o = 4'b01_10;
      TapW'(6): o = 4'b10_00;
      TapW'(7): o = 4'b10_01;
      TapW'(8): o = 4'b10_10;
      default:  o = 4'b01_01;
    endcase
    return o;
  endfunction

endpackage

// ===== hw/rtl/bbr_fifo.sv =====
module bbr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = bbr_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/bbr_front.sv =====
module bbr_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [bbr_pkg::PosW-1:0]  w_i,
  input  logic [bbr_pkg::PosW-1:0]  h_i,
  input  logic                      restart_i,
  input  logic                      accept_i,
  input  bbr_pkg::in_item_t         item_i,
  output bbr_pkg::cmd_t             cmd_o,
  output logic                      cmd_valid_o
);

  localparam int PosW = bbr_pkg::PosW;

  logic [PosW-1:0] in_col_q, in_col_d, in_row_q, in_row_d;
  logic [PosW-1:0] out_col_q, out_col_d, out_row_q, out_row_d;
  logic [PosW-1:0] ic, ir, need_r, need_c;
  logic            store, ready, emit, last;

  always_comb begin
    store = accept_i && (item_i.operation == bbr_pkg::OpPixel) && (in_row_q < h_i);
    ic    = in_col_q;
    ir    = in_row_q;
    if (store) begin
      if (in_col_q + PosW'(1) >= w_i) begin
        ic = '0;
        ir = in_row_q + PosW'(1);
      end else begin
        ic = in_col_q + PosW'(1);
      end
    end

    // the result needs its lower-right neighbor, clamped to the frame
    need_r = (out_row_q + PosW'(1) < h_i) ? out_row_q + PosW'(1) : h_i - PosW'(1);
    need_c = (out_col_q + PosW'(1) < w_i) ? out_col_q + PosW'(1) : w_i - PosW'(1);
    ready  = (ir > need_r) || ((ir == need_r) && (ic > need_c));
    emit   = accept_i && ready;
    last   = (out_row_q == h_i - PosW'(1)) && (out_col_q == w_i - PosW'(1));

    in_col_d  = ic;
    in_row_d  = ir;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (emit) begin
      if (out_col_q + PosW'(1) >= w_i) begin
        out_col_d = '0;
        out_row_d = out_row_q + PosW'(1);
      end else begin
        out_col_d = out_col_q + PosW'(1);
      end
    end
    if ((emit && last) || restart_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end

    cmd_o.store = store;
    cmd_o.emit  = emit;
    cmd_o.last  = last;
    cmd_o.wrow  = in_row_q;
    cmd_o.wcol  = in_col_q;
    cmd_o.orow  = out_row_q;
    cmd_o.ocol  = out_col_q;
    cmd_o.pixel = item_i.pixel_in;
    cmd_valid_o = store || emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

// ===== hw/rtl/bbr_back.sv =====
module bbr_back #(
  parameter int MAX_WIDTH = bbr_pkg::MaxWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [bbr_pkg::PosW-1:0]  w_i,
  input  logic [bbr_pkg::PosW-1:0]  h_i,
  input  bbr_pkg::cmd_t             cmd_i,
  input  logic                      cmd_valid_i,
  output logic                      cmd_pop_o,
  output bbr_pkg::out_item_t        res_o,
  output logic                      res_push_o,
  input  logic                      res_full_i
);

  localparam int PosW  = bbr_pkg::PosW;
  localparam int SumW  = bbr_pkg::SumW;
  localparam int CntW  = bbr_pkg::CntW;
  localparam int ProdW = bbr_pkg::ProdW;
  localparam int TapW  = bbr_pkg::TapW;
  localparam int Sh    = bbr_pkg::RecipShift;
  localparam int ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int AddrW = ColW + 2;
  localparam int Depth = 4 << ColW;

  bbr_pkg::bk_state_e state_q, state_d;

  // four-row line ring, row index is the source row modulo four
  logic [31:0]      ring_mem [Depth];
  logic [31:0]      rd_data_q;
  logic             rd_valid_q;
  logic             wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;

  logic [TapW-1:0]  tap_q;
  logic [PosW-1:0]  row_q, col_q;
  logic             last_q;
  logic [SumW-1:0]  sum_q [4];
  logic [CntW-1:0]  cnt_q;
  logic [ProdW-1:0] prod_q [4];

  logic [3:0]       offs;
  logic [1:0]       dr, dc;
  logic             row_ok, col_ok;
  logic [1:0]       rd_row;
  logic [PosW-1:0]  rd_col;

  always_comb begin
    offs   = bbr_pkg::tap_offs(tap_q);
    dr     = offs[3:2];
    dc     = offs[1:0];
    row_ok = (dr == 2'd0) ? (row_q != '0) :
             (dr == 2'd2) ? (row_q + PosW'(1) < h_i) : 1'b1;
    col_ok = (dc == 2'd0) ? (col_q != '0) :
             (dc == 2'd2) ? (col_q + PosW'(1) < w_i) : 1'b1;
    rd_row  = row_q[1:0] + dr - 2'd1;
    rd_col  = col_q + PosW'(dc) - PosW'(1);
    rd_addr = {rd_row, rd_col[ColW-1:0]};
    wr_addr = {cmd_i.wrow[1:0], cmd_i.wcol[ColW-1:0]};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbr_pkg::BK_IDLE:  if (cmd_valid_i && cmd_i.emit) state_d = bbr_pkg::BK_READ;
      bbr_pkg::BK_READ:  if (tap_q == bbr_pkg::LastTap) state_d = bbr_pkg::BK_DRAIN;
      bbr_pkg::BK_DRAIN: state_d = bbr_pkg::BK_MUL;
      bbr_pkg::BK_MUL:   state_d = bbr_pkg::BK_OUT;
      bbr_pkg::BK_OUT:   if (!res_full_i) state_d = bbr_pkg::BK_IDLE;
      default:           state_d = bbr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = (state_q == bbr_pkg::BK_IDLE) && cmd_valid_i;
    wr_en      = cmd_pop_o && cmd_i.store;
    rd_en      = (state_q == bbr_pkg::BK_READ) && row_ok && col_ok;
    res_push_o = (state_q == bbr_pkg::BK_OUT) && !res_full_i;
    res_o.frame_last = last_q;
    for (int ch = 0; ch < 4; ch++) begin
      res_o.pixel_out[8*ch +: 8] = prod_q[ch][Sh +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bbr_pkg::BK_IDLE;
      rd_valid_q <= 1'b0;
      tap_q      <= '0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= rd_en;
      if (cmd_pop_o) begin
        tap_q <= '0;
      end else if (state_q == bbr_pkg::BK_READ) begin
        tap_q <= tap_q + TapW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= cmd_i.pixel;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      row_q  <= cmd_i.orow;
      col_q  <= cmd_i.ocol;
      last_q <= cmd_i.last;
      cnt_q  <= '0;
      for (int ch = 0; ch < 4; ch++) begin
        sum_q[ch] <= '0;
      end
    end else if (rd_valid_q) begin
      cnt_q <= cnt_q + CntW'(1);
      for (int ch = 0; ch < 4; ch++) begin
        sum_q[ch] <= sum_q[ch] + SumW'(rd_data_q[8*ch +: 8]);
      end
    end
    if (state_q == bbr_pkg::BK_MUL) begin
      for (int ch = 0; ch < 4; ch++) begin
        prod_q[ch] <= ProdW'(sum_q[ch]) * ProdW'(bbr_pkg::recip(cnt_q));
      end
    end
  end

endmodule

// ===== hw/rtl/box_blur_3x3_rgba_core.sv =====
// 3x3 box blur over a raster stream of 32-bit RGBA pixels
// input side is a queue: write an item with push while full is low; an item
// with operation 0 carries a source pixel, operation 1 is a flush tick
// result side is a queue: while empty is low the oldest result is on
// out_item_o, take it with pop; frame_last marks the bottom-right pixel
// results trail the source by about one row plus one pixel; after the last
// source pixel, each flush tick drains one pending result
// config channel: cfg_valid_i/cfg_ready_o with index 0 image width and
// 1 image height, write only while idle; a write to either restarts the frame
// an item that yields no result is popped whenever the back end is idle; an
// item that yields a result holds the back end through nine sequential tap steps,
// each reading the line ring for an in-frame tap, then drain, multiply, hand-off
// a two-entry command queue lets the front keep accepting meanwhile
// a stalled consumer fills the two-entry result queue, then the back end
// holds, then the command queue fills and full rises
// reset clears all positions and queues; width comes back 640, height 480
module box_blur_3x3_rgba_core #(
  parameter int MAX_WIDTH  = bbr_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = bbr_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  bbr_pkg::in_item_t             in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output bbr_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bbr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bbr_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int PosW  = bbr_pkg::PosW;
  localparam int SizeW = bbr_pkg::SizeW;
  localparam int CmdW  = $bits(bbr_pkg::cmd_t);
  localparam int ResW  = $bits(bbr_pkg::out_item_t);

  logic [SizeW-1:0]    width_q, height_q;
  logic [PosW-1:0]     w_eff, h_eff;
  logic                cfg_wr, restart, accept;
  bbr_pkg::cmd_t       cmd_in, cmd_out;
  logic                cmd_valid, cmd_full, cmd_empty, cmd_pop;
  bbr_pkg::out_item_t  res;
  logic                res_push, res_full;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_wr && ((cfg_index_i == bbr_pkg::CfgImageWidth) ||
                                  (cfg_index_i == bbr_pkg::CfgImageHeight));
  assign w_eff       = bbr_pkg::clamp_size(width_q, MAX_WIDTH);
  assign h_eff       = bbr_pkg::clamp_size(height_q, MAX_HEIGHT);
  assign full        = cmd_full;
  assign accept      = push && !cmd_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bbr_pkg::WidthReset;
      height_q <= bbr_pkg::HeightReset;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        bbr_pkg::CfgImageWidth:  width_q  <= cfg_data_i[SizeW-1:0];
        bbr_pkg::CfgImageHeight: height_q <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  bbr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .w_i         (w_eff),
    .h_i         (h_eff),
    .restart_i   (restart),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .cmd_o       (cmd_in),
    .cmd_valid_o (cmd_valid)
  );

  bbr_fifo #(
    .W     (CmdW),
    .DEPTH (bbr_pkg::QueueDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  bbr_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .w_i         (w_eff),
    .h_i         (h_eff),
    .cmd_i       (cmd_out),
    .cmd_valid_i (!cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  bbr_fifo #(
    .W     (ResW),
    .DEPTH (bbr_pkg::QueueDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

endmodule

// ===== hw/rtl/bbr_checker.sv =====
`include "assert_macros.svh"

module bbr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input bbr_pkg::out_item_t out_item_o,
  input logic               cfg_ready_o
);

  // config channel never back-pressures
  `ASSERT_IMPL(a_cfg_ready, clk_i, rst_ni, 1'b1, cfg_ready_o, "config channel not ready")

  // a waiting result that is not taken stays put
  `ASSERT_NEXT(a_res_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_item_o), "result changed while stalled")

  // nothing waits right after reset is released
  `ASSERT_IMPL(a_reset_empty, clk_i, rst_ni, $rose(rst_ni), empty, "result queue not empty after reset")

endmodule

bind box_blur_3x3_rgba_core bbr_checker u_bbr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .out_item_o  (out_item_o),
  .cfg_ready_o (cfg_ready_o)
);

// ===== verif/tb_box_blur_3x3_rgba_core.sv =====
`timescale 1ns / 1ps

module tb_box_blur_3x3_rgba_core;
  import bbr_pkg::*;

  localparam logic OpFlush = 1'b1;
  localparam int MaxW = 1024;
  localparam int MaxH = 1024;
  localparam int SettleCycles = 40;
  localparam int ClampCut = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t in_item_i = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  box_blur_3x3_rgba_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .in_item_i(in_item_i),
    .empty(empty),
    .pop(pop),
    .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the blur state
  logic [SizeW-1:0] width_reg = WidthReset;
  logic [SizeW-1:0] height_reg = HeightReset;
  logic [31:0] row_ring [4][MaxW];
  int unsigned src_col, src_row, dst_col, dst_row;

  in_item_t pixel_stream[$];
  out_item_t blurred_q[$];
  int unsigned fail_cnt = 0;
  int unsigned item_cnt = 0;
  bit no_gaps = 1'b0;
  int unsigned push_gap = 0;
  int unsigned pop_gap = 0;

  function automatic int unsigned eff_size(logic [SizeW-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  function automatic void restart_positions();
    src_col = 0;
    src_row = 0;
    dst_col = 0;
    dst_row = 0;
  endfunction

  function automatic logic [31:0] mean_at(int unsigned r, int unsigned c,
                                          int unsigned w, int unsigned h);
    int unsigned sum [4];
    int unsigned cnt;
    int rr, cc;
    logic [31:0] px, res;
    cnt = 0;
    res = '0;
    for (int ch = 0; ch < 4; ch++) sum[ch] = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      rr = int'(r) + dr;
      if (rr < 0 || rr >= int'(h)) continue;
      for (int dc = -1; dc <= 1; dc++) begin
        cc = int'(c) + dc;
        if (cc < 0 || cc >= int'(w)) continue;
        px = row_ring[rr & 3][cc];
        for (int ch = 0; ch < 4; ch++) sum[ch] += px[8*ch +: 8];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    for (int ch = 0; ch < 4; ch++) res[8*ch +: 8] = 8'(sum[ch] / cnt);
    return res;
  endfunction

  function automatic void predict_blur(in_item_t it);
    int unsigned w, h, got, need_r, need_c;
    out_item_t exp_item;
    w = eff_size(width_reg, MaxW);
    h = eff_size(height_reg, MaxH);
    if (src_col >= w || dst_col >= w || src_row > h || dst_row >= h) restart_positions();
    if (it.operation == OpPixel && src_row < h) begin
      row_ring[src_row & 3][src_col] = it.pixel_in;
      src_col++;
      if (src_col >= w) begin
        src_col = 0;
        src_row++;
      end
    end
    got = src_row * w + src_col;
    need_r = (dst_row + 1 < h) ? dst_row + 1 : h - 1;
    need_c = (dst_col + 1 < w) ? dst_col + 1 : w - 1;
    if (got <= need_r * w + need_c) return;
    exp_item.frame_last = (dst_row == h - 1) && (dst_col == w - 1);
    exp_item.pixel_out = mean_at(dst_row, dst_col, w, h);
    blurred_q.push_back(exp_item);
    dst_col++;
    if (dst_col >= w) begin
      dst_col = 0;
      dst_row++;
    end
    if (exp_item.frame_last) restart_positions();
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) predict_blur(in_item_i);
      if (!push || !full) begin
        if (push_gap > 0) begin
          push_gap <= push_gap - 1;
          push <= 1'b0;
        end else if (pixel_stream.size() > 0) begin
          push <= 1'b1;
          in_item_i <= pixel_stream.pop_front();
          push_gap <= pick_gap();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (blurred_q.size() == 0) begin
          $error("result beat with nothing expected: pixel_out %h", out_item_o.pixel_out);
          fail_cnt++;
        end else begin
          exp_item = blurred_q.pop_front();
          if (out_item_o.pixel_out !== exp_item.pixel_out) begin
            $error("pixel_out expected %h actual %h", exp_item.pixel_out,
                   out_item_o.pixel_out);
            fail_cnt++;
          end
          if (out_item_o.frame_last !== exp_item.frame_last) begin
            $error("frame_last expected %0b actual %0b", exp_item.frame_last,
                   out_item_o.frame_last);
            fail_cnt++;
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        pop_gap <= pick_gap();
      end
    end
  end

  task automatic wait_drained();
    while (pixel_stream.size() != 0 || push || blurred_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [SizeW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CfgDataW'(val);
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
    if (idx == CfgImageWidth) width_reg = val;
    else height_reg = val;
    restart_positions();
  endtask

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                 {8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}}};
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_item(logic op, logic [31:0] px);
    in_item_t it;
    it.operation = op;
    it.pixel_in = px;
    pixel_stream.push_back(it);
    item_cnt++;
  endfunction

  // one frame: pixels with optional stray flushes, then a drain tail that is
  // flushes or dropped pixels; cut_at < total stops the frame early
  task automatic add_frame(int unsigned w, int unsigned h, bit stray, bit pushy_tail,
                           int unsigned cut_at, bit pause_mid);
    int unsigned total;
    total = w * h;
    for (int unsigned i = 0; i < total && i < cut_at; i++) begin
      if (pause_mid && i == total / 2) wait_drained();
      if (stray && $urandom_range(0, 5) == 0) add_item(OpFlush, $urandom);
      add_item(OpPixel, rand_pixel());
    end
    if (cut_at < total) return;
    for (int unsigned i = 0; i < w + 1; i++)
      add_item(pushy_tail ? OpPixel : OpFlush, $urandom);
    // idle flushes once the frame is done
    repeat ($urandom_range(0, 2)) add_item(OpFlush, $urandom);
  endtask

  task automatic set_size(logic [SizeW-1:0] w, logic [SizeW-1:0] h);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if ($urandom_range(0, 1)) begin
      write_reg(CfgImageWidth, w);
      write_reg(CfgImageHeight, h);
    end else begin
      write_reg(CfgImageHeight, h);
      write_reg(CfgImageWidth, w);
    end
  endtask

  initial begin
    int unsigned w, h;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner, edge and interior divisors, extreme pixels, stray and idle flushes
    set_size(3, 3);
    add_item(OpFlush, '1);
    for (int i = 0; i < 9; i++) add_item(OpPixel, (i % 2) ? 32'hFFFF_FFFF : 32'h0);
    add_item(OpFlush, 32'h0);
    add_item(OpPixel, 32'h1234_5678);
    repeat (4) add_item(OpFlush, '0);
    add_item(OpFlush, '1);

    // zero sizes count as one
    set_size(0, 0);
    add_frame(1, 1, 1'b0, 1'b0, 1, 1'b0);
    // oversized sizes clamp to the maximum, leading part of the frame only
    set_size(11'h7FF, 1);
    add_frame(MaxW, 1, 1'b0, 1'b0, ClampCut, 1'b0);
    set_size(1, 11'h7FF);
    add_frame(1, MaxH, 1'b0, 1'b1, ClampCut, 1'b0);
    set_size(MaxW, 2);
    add_frame(MaxW, 2, 1'b1, 1'b0, ClampCut, 1'b0);

    while (item_cnt < 850) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      no_gaps = ($urandom_range(0, 4) == 0);
      set_size(($urandom_range(0, 15) == 0) ? 11'd0 : SizeW'(w), SizeW'(h));
      if ($urandom_range(0, 15) == 0) w = 1;
      if ($urandom_range(0, 7) == 0)
        add_frame(w, h, 1'b1, 1'b0, $urandom_range(0, w * h - 1), 1'b0);
      else
        add_frame(w, h, $urandom_range(0, 1), ($urandom_range(0, 3) == 0),
                  w * h, ($urandom_range(0, 9) == 0));
      if ($urandom_range(0, 2) == 0) add_frame(w, h, 1'b0, 1'b0, w * h, 1'b0);
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (blurred_q.size() != 0) begin
      $error("%0d expected results never arrived", blurred_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bbr_pkg.sv
hw/rtl/bbr_fifo.sv
hw/rtl/bbr_front.sv
hw/rtl/bbr_back.sv
hw/rtl/box_blur_3x3_rgba_core.sv
hw/rtl/bbr_checker.sv
verif/tb_box_blur_3x3_rgba_core.sv
